// ----- design/gmr_pkg.sv -----
// Shared types, constants and the microprogram of the grid maze reachability block.
package gmr_pkg;

  localparam int CoordW        = 3;
  localparam int EntryW        = 2 * CoordW;
  localparam int OpenW         = 64;
  localparam int OpenIdxW      = 6;
  localparam int InDataW       = 16;
  localparam int OutDataW      = 8;
  localparam int GridSideDef   = 8;
  localparam int StackDepthDef = 64;

  typedef logic [3:0] upc_t;

  localparam upc_t S_IDLE  = 4'd0;
  localparam upc_t S_START = 4'd1;
  localparam upc_t S_POP   = 4'd2;
  localparam upc_t S_TEST  = 4'd3;
  localparam upc_t S_UP    = 4'd4;
  localparam upc_t S_DOWN  = 4'd5;
  localparam upc_t S_LEFT  = 4'd6;
  localparam upc_t S_RIGHT = 4'd7;
  localparam upc_t S_EMIT  = 4'd8;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_START,
    OP_POP,
    OP_TEST,
    OP_PUSH,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_REQ,
    COND_BAD,
    COND_EMPTY,
    COND_MATCH,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    dir_e  dir;
    upc_t  tgt_t;
    upc_t  tgt_f;
  } ctrl_word_t;

  typedef struct packed {
    logic req;
    logic bad;
    logic empty;
    logic match;
    logic out_busy;
  } flags_t;

  function automatic ctrl_word_t ucode_rom(upc_t addr);
    ctrl_word_t w;
    unique case (addr)
      S_IDLE:  w = '{OP_ACCEPT, COND_NO_REQ,   DIR_UP,    S_IDLE, S_START};
      S_START: w = '{OP_START,  COND_BAD,      DIR_UP,    S_EMIT, S_POP};
      S_POP:   w = '{OP_POP,    COND_EMPTY,    DIR_UP,    S_EMIT, S_TEST};
      S_TEST:  w = '{OP_TEST,   COND_MATCH,    DIR_UP,    S_EMIT, S_UP};
      S_UP:    w = '{OP_PUSH,   COND_NONE,     DIR_UP,    S_DOWN, S_DOWN};
      S_DOWN:  w = '{OP_PUSH,   COND_NONE,     DIR_DOWN,  S_LEFT, S_LEFT};
      S_LEFT:  w = '{OP_PUSH,   COND_NONE,     DIR_LEFT,  S_RIGHT, S_RIGHT};
      S_RIGHT: w = '{OP_PUSH,   COND_NONE,     DIR_RIGHT, S_POP, S_POP};
      S_EMIT:  w = '{OP_EMIT,   COND_OUT_BUSY, DIR_UP,    S_EMIT, S_IDLE};
      default: w = '{OP_ACCEPT, COND_NO_REQ,   DIR_UP,    S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- design/gmr_sequencer.sv -----
// Microcode step counter with conditional jumps over the control store.
module gmr_sequencer
  import gmr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  flags_t     flags_i,
  output ctrl_word_t ctrl_o
);

  upc_t       pc_q, pc_d;
  ctrl_word_t word;
  logic       cond_true;

  always_comb begin
    word   = ucode_rom(pc_q);
    ctrl_o = word;
  end

  always_comb begin
    unique case (word.cond)
      COND_NONE:     cond_true = 1'b0;
      COND_NO_REQ:   cond_true = !flags_i.req;
      COND_BAD:      cond_true = flags_i.bad;
      COND_EMPTY:    cond_true = flags_i.empty;
      COND_MATCH:    cond_true = flags_i.match;
      COND_OUT_BUSY: cond_true = flags_i.out_busy;
      default:       cond_true = 1'b0;
    endcase
    pc_d = cond_true ? word.tgt_t : word.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- design/grid_maze_reachability_top.sv -----
// Grid maze reachability: depth-first search over an open-cell map with a stack memory.
// A request gives a start and a destination cell; the block walks the open cells of the
// grid held in the configuration register with a depth-first search and returns one
// result bit, 1 when the destination can be reached and 0 when a coordinate lies outside
// the grid. The search time is set by the single-port stack memory and by the microcode,
// which checks one neighbor per step. One request is worked on at a time; a new request
// is taken as soon as the result sits in the output register.
module grid_maze_reachability_top
  import gmr_pkg::*;
#(
  parameter int GRID_SIDE   = GridSideDef,
  parameter int STACK_DEPTH = StackDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [OpenW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // start_row [2:0], start_col [5:3], dest_row [8:6], dest_col [11:9], zero [15:12]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // reachable [0], zero [7:1]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int NumCells = GRID_SIDE * GRID_SIDE;
  localparam int CellW    = $clog2(NumCells);
  localparam int CntW     = $clog2(STACK_DEPTH + 1);
  localparam int AddrW    = $clog2(STACK_DEPTH);
  localparam logic [CoordW:0] SideL  = (CoordW + 1)'(GRID_SIDE);
  localparam logic [CntW-1:0] DepthL = CntW'(STACK_DEPTH);

  ctrl_word_t ctrl;
  flags_t     flags;

  logic [OpenW-1:0]    open_q;
  logic [NumCells-1:0] visited_q;
  logic [CntW-1:0]     cnt_q;
  logic [EntryW-1:0]   stack_mem [STACK_DEPTH];
  logic [EntryW-1:0]   rd_data_q;
  logic [CoordW-1:0]   srow_q, scol_q, drow_q, dcol_q;
  logic                found_q;
  logic                out_valid_q;
  logic                out_data_q;

  logic                accept;
  logic                bad;
  logic [CoordW-1:0]   cur_row, cur_col;
  logic [CoordW-1:0]   nb_row, nb_col;
  logic                nb_in;
  logic [CoordW-1:0]   push_row, push_col;
  logic [CellW-1:0]    push_idx;
  logic                nb_free;
  logic                full;
  logic                do_push;
  logic                do_pop;
  logic                out_busy;
  logic [CntW-1:0]     cnt_dec;

  gmr_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign s_axis_tready = (ctrl.op == OP_ACCEPT);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign bad = ({1'b0, srow_q} >= SideL) || ({1'b0, scol_q} >= SideL) ||
               ({1'b0, drow_q} >= SideL) || ({1'b0, dcol_q} >= SideL);

  assign cur_row  = rd_data_q[EntryW-1:CoordW];
  assign cur_col  = rd_data_q[CoordW-1:0];
  assign full     = (cnt_q == DepthL);
  assign out_busy = out_valid_q && !m_axis_tready;
  assign cnt_dec  = cnt_q - CntW'(1);

  always_comb begin
    nb_row = cur_row;
    nb_col = cur_col;
    nb_in  = 1'b0;
    unique case (ctrl.dir)
      DIR_UP: begin
        nb_row = cur_row - CoordW'(1);
        nb_in  = (cur_row != '0);
      end
      DIR_DOWN: begin
        nb_row = cur_row + CoordW'(1);
        nb_in  = ({1'b0, cur_row} + (CoordW + 1)'(1)) < SideL;
      end
      DIR_LEFT: begin
        nb_col = cur_col - CoordW'(1);
        nb_in  = (cur_col != '0);
      end
      DIR_RIGHT: begin
        nb_col = cur_col + CoordW'(1);
        nb_in  = ({1'b0, cur_col} + (CoordW + 1)'(1)) < SideL;
      end
      default: begin
        nb_in = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (ctrl.op == OP_START) begin
      push_row = srow_q;
      push_col = scol_q;
    end else begin
      push_row = nb_row;
      push_col = nb_col;
    end
    push_idx = CellW'(int'(push_row) * GRID_SIDE + int'(push_col));
    nb_free  = nb_in && open_q[OpenIdxW'(push_idx)] && !visited_q[push_idx];
    do_push  = ((ctrl.op == OP_PUSH) && nb_free && !full) ||
               ((ctrl.op == OP_START) && !bad);
    do_pop   = (ctrl.op == OP_POP) && (cnt_q != '0);
  end

  always_comb begin
    flags.req      = s_axis_tvalid;
    flags.bad      = bad;
    flags.empty    = (cnt_q == '0);
    flags.match    = (cur_row == drow_q) && (cur_col == dcol_q);
    flags.out_busy = out_busy;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_mem[cnt_q[AddrW-1:0]] <= {push_row, push_col};
    end
    if (do_pop) begin
      rd_data_q <= stack_mem[cnt_dec[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      srow_q <= s_axis_tdata[CoordW-1:0];
      scol_q <= s_axis_tdata[2*CoordW-1:CoordW];
      drow_q <= s_axis_tdata[3*CoordW-1:2*CoordW];
      dcol_q <= s_axis_tdata[4*CoordW-1:3*CoordW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '0;
      visited_q   <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        open_q <= cfg_wdata_i;
      end
      if (accept) begin
        visited_q <= '0;
        cnt_q     <= '0;
        found_q   <= 1'b0;
      end else if (do_push) begin
        visited_q[push_idx] <= 1'b1;
        cnt_q               <= cnt_q + CntW'(1);
      end else if (do_pop) begin
        cnt_q <= cnt_dec;
      end
      if (ctrl.op == OP_TEST) begin
        found_q <= flags.match;
      end
      if ((ctrl.op == OP_EMIT) && !out_busy) begin
        out_valid_q <= 1'b1;
        out_data_q  <= found_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 1){1'b0}}, out_data_q};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthL)
    else $error("stack count beyond stack depth");

  a_cnt_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= $countones(visited_q))
    else $error("more stacked cells than visited cells");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl.op == OP_EMIT) && !out_busy) |=> (m_axis_tvalid && s_axis_tready))
    else $error("result not presented after emit step");
`endif

endmodule
